// ----- src/hcbd_pkg.sv -----
// Shared types and constants for the HTTP chunked body decoder.
// Holds the item structs, character codes and status codes; no dependencies.
`default_nettype none
package hcbd_pkg;

  localparam int unsigned MaxSizeChars = 15;
  localparam int unsigned SizeBits     = 32;
  localparam int unsigned CharCntBits  = 4;

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;

  localparam logic [1:0] StatusRun  = 2'd0;
  localparam logic [1:0] StatusDone = 2'd1;
  localparam logic [1:0] StatusErr  = 2'd2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       new_stream;
  } in_item_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic [1:0] status;
  } out_item_t;

endpackage
`default_nettype wire

// ----- src/http_chunked_body_decoder_core.sv -----
// Top level of the HTTP chunked body decoder: parser state and result register.
// Depends on hcbd_pkg for the item structs and constants.
//
// The decoder takes one byte of a chunked body per item and returns exactly one
// result item per input item, one item per clock cycle when the output side takes
// results as they come. The parser state updates in the cycle an item is accepted
// and the result is held in a single output register; in_ready_o is high whenever
// that register is empty or is being emptied in the same cycle, so throughput is
// set by the output handshake alone and a result is valid from the cycle after
// its item is accepted. After reset the decoder waits for a chunk-size line. Done
// and error status stay until an item with new_stream set restarts the parser.
`default_nettype none
module http_chunked_body_decoder_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hcbd_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hcbd_pkg::out_item_t     out_item_o
);

  localparam logic [2:0] PhSize   = 3'd0;
  localparam logic [2:0] PhExt    = 3'd1;
  localparam logic [2:0] PhSizeLf = 3'd2;
  localparam logic [2:0] PhData   = 3'd3;
  localparam logic [2:0] PhDataCr = 3'd4;
  localparam logic [2:0] PhDataLf = 3'd5;
  localparam logic [2:0] PhDone   = 3'd6;
  localparam logic [2:0] PhError  = 3'd7;

  localparam int unsigned SB = hcbd_pkg::SizeBits;
  localparam int unsigned CB = hcbd_pkg::CharCntBits;

  logic [2:0]    phase_q, phase_d, phase_cur;
  logic [SB-1:0] size_q, size_d, size_cur;
  logic [CB-1:0] chars_q, chars_d, chars_cur;
  logic          stop_q, stop_d, stop_cur;
  logic [SB-1:0] left_q, left_d, left_cur;
  logic [SB-1:0] left_dec;

  logic                out_valid_q;
  hcbd_pkg::out_item_t out_q, out_d;

  logic       accept;
  logic [7:0] c;
  logic       is_hex;
  logic [3:0] hex_val;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign c           = in_item_i.byte_in;
  assign left_dec    = left_cur - SB'(1);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    if (in_item_i.new_stream) begin
      phase_cur = PhSize;
      size_cur  = '0;
      chars_cur = '0;
      stop_cur  = 1'b0;
      left_cur  = '0;
    end else begin
      phase_cur = phase_q;
      size_cur  = size_q;
      chars_cur = chars_q;
      stop_cur  = stop_q;
      left_cur  = left_q;
    end

    phase_d = phase_cur;
    size_d  = size_cur;
    chars_d = chars_cur;
    stop_d  = stop_cur;
    left_d  = left_cur;
    out_d.body_valid = 1'b0;
    out_d.body_byte  = 8'd0;

    unique case (phase_cur)
      PhSize: begin
        if (c == hcbd_pkg::ChCr) begin
          phase_d = PhSizeLf;
        end else if (c == hcbd_pkg::ChSemi) begin
          phase_d = PhExt;
        end else if (chars_cur >= CB'(hcbd_pkg::MaxSizeChars)) begin
          phase_d = PhError;
        end else begin
          chars_d = chars_cur + CB'(1);
          if (!is_hex) begin
            stop_d = 1'b1;
          end else if (!stop_cur) begin
            if (size_cur[SB-1 -: 4] != 4'd0) begin
              size_d = '1;
            end else begin
              size_d = {size_cur[SB-5:0], hex_val};
            end
          end
        end
      end
      PhExt: begin
        if (c == hcbd_pkg::ChCr) begin
          phase_d = PhSizeLf;
        end
      end
      PhSizeLf: begin
        if (c != hcbd_pkg::ChLf) begin
          phase_d = PhError;
        end else if (size_cur == '0) begin
          phase_d = PhDone;
        end else begin
          left_d  = size_cur;
          phase_d = PhData;
        end
      end
      PhData: begin
        out_d.body_valid = 1'b1;
        out_d.body_byte  = c;
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = PhDataCr;
        end
      end
      PhDataCr: begin
        phase_d = (c == hcbd_pkg::ChCr) ? PhDataLf : PhError;
      end
      PhDataLf: begin
        if (c == hcbd_pkg::ChLf) begin
          phase_d = PhSize;
          size_d  = '0;
          chars_d = '0;
          stop_d  = 1'b0;
        end else begin
          phase_d = PhError;
        end
      end
      default: begin
      end
    endcase

    if (phase_d == PhDone) begin
      out_d.status = hcbd_pkg::StatusDone;
    end else if (phase_d == PhError) begin
      out_d.status = hcbd_pkg::StatusErr;
    end else begin
      out_d.status = hcbd_pkg::StatusRun;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSize;
      size_q      <= '0;
      chars_q     <= '0;
      stop_q      <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        size_q  <= size_d;
        chars_q <= chars_d;
        stop_q  <= stop_d;
        left_q  <= left_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/hcbd_checker.sv -----
// Port-level checker for the HTTP chunked body decoder, bound to the top level.
// Depends on hcbd_pkg for the item structs and status codes.
`default_nettype none
module hcbd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire hcbd_pkg::in_item_t  in_item_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire hcbd_pkg::out_item_t out_item_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_item_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Result item changed while stalled.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled while the result register could move.");

  a_data_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.body_valid |-> out_item_o.status == hcbd_pkg::StatusRun)
    else $error("Payload byte reported with a done or error status.");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.body_valid |-> out_item_o.body_byte == 8'd0)
    else $error("Nonzero body byte without body_valid.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status == hcbd_pkg::StatusRun ||
                    out_item_o.status == hcbd_pkg::StatusDone ||
                    out_item_o.status == hcbd_pkg::StatusErr)
    else $error("Undefined status code.");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for http_chunked_body_decoder_core: a tracker class predicts
// each result from the accepted bytes, and tasks drive well-formed and broken chunked bodies.
// Depends on hcbd_pkg and the decoder RTL only.

typedef enum logic [2:0] {
  PhSize, PhExt, PhSizeLf, PhData, PhDataCr, PhDataLf, PhDone, PhError
} parse_phase_e;

class body_decode_tracker;
  parse_phase_e                      phase;
  logic [hcbd_pkg::SizeBits-1:0]     size_value;
  logic [hcbd_pkg::SizeBits-1:0]     bytes_left;
  logic [hcbd_pkg::CharCntBits-1:0]  size_chars;
  logic                              hex_stopped;
  hcbd_pkg::out_item_t               awaited_q[$];
  int                                errors;

  function new();
    begin_size_line();
    bytes_left = '0;
    errors = 0;
  endfunction

  function void begin_size_line();
    phase = PhSize;
    size_value = '0;
    size_chars = '0;
    hex_stopped = 1'b0;
  endfunction

  function void predict_byte(hcbd_pkg::in_item_t it);
    logic [7:0]          c;
    int                  digit;
    hcbd_pkg::out_item_t res;
    c = it.byte_in;
    res = '0;
    digit = -1;
    if (c >= 8'h30 && c <= 8'h39) digit = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) digit = c - 8'h41 + 10;
    else if (c >= 8'h61 && c <= 8'h66) digit = c - 8'h61 + 10;
    if (it.new_stream) begin
      begin_size_line();
      bytes_left = '0;
    end
    case (phase)
      PhSize: begin
        if (c == hcbd_pkg::ChCr) begin
          phase = PhSizeLf;
        end else if (c == hcbd_pkg::ChSemi) begin
          phase = PhExt;
        end else if (size_chars >= hcbd_pkg::MaxSizeChars) begin
          phase = PhError;
        end else begin
          size_chars = size_chars + 1'b1;
          if (digit < 0) begin
            hex_stopped = 1'b1;
          end else if (!hex_stopped) begin
            if (size_value[hcbd_pkg::SizeBits-1 -: 4] != '0) size_value = '1;
            else size_value = {size_value[hcbd_pkg::SizeBits-5:0], 4'(digit)};
          end
        end
      end
      PhExt: begin
        if (c == hcbd_pkg::ChCr) phase = PhSizeLf;
      end
      PhSizeLf: begin
        if (c != hcbd_pkg::ChLf) begin
          phase = PhError;
        end else if (size_value == '0) begin
          phase = PhDone;
        end else begin
          bytes_left = size_value;
          phase = PhData;
        end
      end
      PhData: begin
        res.body_valid = 1'b1;
        res.body_byte = c;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) phase = PhDataCr;
      end
      PhDataCr: begin
        phase = (c == hcbd_pkg::ChCr) ? PhDataLf : PhError;
      end
      PhDataLf: begin
        if (c == hcbd_pkg::ChLf) begin_size_line();
        else phase = PhError;
      end
      default: begin
      end
    endcase
    res.status = (phase == PhDone) ? hcbd_pkg::StatusDone :
                 (phase == PhError) ? hcbd_pkg::StatusErr : hcbd_pkg::StatusRun;
    awaited_q.push_back(res);
  endfunction

  function void check_output(hcbd_pkg::out_item_t got);
    hcbd_pkg::out_item_t exp;
    if (awaited_q.size() == 0) begin
      $error("result with nothing awaited: valid %0d byte %0h status %0d",
             got.body_valid, got.body_byte, got.status);
      errors++;
      return;
    end
    exp = awaited_q.pop_front();
    if (got.body_valid !== exp.body_valid) begin
      $error("body_valid: expected %0d, got %0d", exp.body_valid, got.body_valid);
      errors++;
    end
    if (got.body_byte !== exp.body_byte) begin
      $error("body_byte: expected %0h, got %0h", exp.body_byte, got.body_byte);
      errors++;
    end
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int ItemTarget = 1480;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  hcbd_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  hcbd_pkg::out_item_t out_item;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          items_sent;
  bit          restart_next;

  body_decode_tracker tracker;

  http_chunked_body_decoder_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_output(out_item);
  end

  function automatic logic [7:0] byte_other_than(logic [7:0] avoid);
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (ch == avoid);
    return ch;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return 8'h30 + nib;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  // Any byte that the size line counts but that is not a hex digit.
  function automatic logic [7:0] nonhex_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (ch == hcbd_pkg::ChCr || ch == hcbd_pkg::ChSemi || (ch >= 8'h30 && ch <= 8'h39) ||
           (ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66));
    return ch;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_byte(input logic [7:0] b);
    hcbd_pkg::in_item_t nxt;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    nxt.byte_in = b;
    nxt.new_stream = restart_next;
    restart_next = 1'b0;
    in_valid <= 1'b1;
    in_item <= nxt;
    do @(posedge clk); while (!in_ready);
    tracker.predict_byte(nxt);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic send_crlf();
    push_byte(hcbd_pkg::ChCr);
    push_byte(hcbd_pkg::ChLf);
  endtask

  task automatic send_size_line(input logic [31:0] size, input bit tidy);
    int         nd;
    int         pad;
    int         junk;
    logic [7:0] ch;
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    pad = 0;
    junk = 0;
    if (!tidy) begin
      pad = $urandom_range(15 - nd);
      junk = $urandom_range(15 - nd - pad);
    end
    repeat (pad) push_byte(8'h30);
    for (int i = nd - 1; i >= 0; i--) push_byte(hex_char(size[4 * i +: 4]));
    repeat (junk) push_byte(nonhex_byte());
    if ($urandom_range(3) == 0) begin
      push_byte(hcbd_pkg::ChSemi);
      repeat ($urandom_range(6)) push_byte(byte_other_than(hcbd_pkg::ChCr));
    end
    send_crlf();
  endtask

  task automatic run_stream();
    int fault;
    int chunks;
    int len;
    restart_next = 1'b1;
    fault = ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 7);
    chunks = $urandom_range(1, 4);
    for (int k = 0; k < chunks; k++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      send_size_line(len, 1'($urandom_range(1)));
      repeat (len) push_byte(8'($urandom_range(255)));
      if (fault != 0 && k == chunks - 1) break;
      send_crlf();
    end
    case (fault)
      0: begin
        send_size_line(0, 1'($urandom_range(1)));
      end
      1: begin
        push_byte(byte_other_than(hcbd_pkg::ChCr));
      end
      2: begin
        push_byte(hcbd_pkg::ChCr);
        push_byte(byte_other_than(hcbd_pkg::ChLf));
      end
      3: begin
        send_crlf();
        push_byte(hex_char(4'($urandom_range(1, 15))));
        push_byte(hcbd_pkg::ChCr);
        push_byte(byte_other_than(hcbd_pkg::ChLf));
      end
      4: begin
        send_crlf();
        repeat (16) begin
          push_byte($urandom_range(1) ? hex_char(4'($urandom_range(15))) : nonhex_byte());
        end
      end
      5: begin
        repeat (20) begin
          restart_next = ($urandom_range(15) == 0);
          push_byte(8'($urandom_range(255)));
        end
      end
      6: begin
        send_crlf();
        push_byte(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 13)) push_byte(hex_char(4'($urandom_range(15))));
        send_crlf();
        repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(255)));
      end
      default: begin
        send_crlf();
        repeat ($urandom_range(3)) push_byte(nonhex_byte());
        send_crlf();
      end
    endcase
    repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    restart_next = 1'b0;
    tracker = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Two data bytes at the byte extremes, then an extension-only size line ends the stream.
    restart_next = 1'b1;
    send_text("2");
    send_crlf();
    push_byte(8'h00);
    push_byte(8'hFF);
    send_crlf();
    push_byte(hcbd_pkg::ChSemi);
    push_byte(8'h80);
    send_crlf();
    // A saturating size, a non-hex stop, then a sixteenth size-line character.
    restart_next = 1'b1;
    send_text("fFfFfFfFfX12345");
    send_text("7");

    while (items_sent < ItemTarget) begin
      case ((items_sent / 370) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      run_stream();
    end
    in_valid <= 1'b0;

    while (tracker.awaited_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited_q.size() == 0) begin
      $display("PASS http_chunked_body_decoder_core");
    end else begin
      $display("FAIL http_chunked_body_decoder_core");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL http_chunked_body_decoder_core");
    $finish;
  end

endmodule

// ----- http_chunked_body_decoder_core.f -----
src/hcbd_pkg.sv
src/http_chunked_body_decoder_core.sv
src/hcbd_checker.sv
tb/tb_top.sv
